/* design/sccg_pkg.sv */
// Shared types and constants for the serial CRC generate/check unit.
package sccg_pkg;

  // Upper bound on the CRC length handled by the datapath
  localparam int MAX_CHECK_WIDTH = 32;

  // Width of the CRC length register and of width-related counters
  localparam int CW_W = 6;

  // Configuration register indexes
  localparam logic [1:0] CFG_DIVISOR = 2'd0;
  localparam logic [1:0] CFG_WIDTH   = 2'd1;
  localparam logic [1:0] CFG_MODE    = 2'd2;

  // Configuration reset values
  localparam logic [31:0]     DIVISOR_RST = 32'd5;
  localparam logic [CW_W-1:0] WIDTH_RST   = 6'd3;
  localparam logic            MODE_RST    = 1'b0;

  // Depth of the job queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Kind of work handed from front to back
  typedef enum logic [1:0] {
    JOB_ECHO,
    JOB_CRC,
    JOB_VERDICT
  } job_kind_t;

  // One queued job (the remainder snapshot travels beside it)
  typedef struct packed {
    job_kind_t         kind;
    logic              data_bit;
    logic              error;
    logic [CW_W-1:0]   width;
  } job_t;

endpackage

/* design/sccg_front.sv */
// Front end: configuration registers, bit-serial division and job classification.
module sccg_front #(
  parameter int MAX_CHECK_WIDTH = sccg_pkg::MAX_CHECK_WIDTH,
  localparam int CAP_W = (MAX_CHECK_WIDTH < 32) ? MAX_CHECK_WIDTH : 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  input  logic [1:0]             cfg_index,
  input  logic [31:0]            cfg_data,
  input  logic                   in_valid,
  input  logic                   in_data_bit,
  input  logic                   in_final_bit,
  output logic                   in_stall,
  input  logic                   full_i,
  output logic                   push_o,
  output sccg_pkg::job_t         job_o,
  output logic [CAP_W-1:0]       rem_o
);

  localparam logic [sccg_pkg::CW_W-1:0] CAP_WV = sccg_pkg::CW_W'(CAP_W);

  logic [31:0]               divisor_r;
  logic [sccg_pkg::CW_W-1:0] check_width_r;
  logic                      check_mode_r;
  logic [CAP_W-1:0]          rem_r;
  logic [CAP_W-1:0]          rem_nxt;

  logic [sccg_pkg::CW_W-1:0] eff_w;
  logic [CAP_W-1:0]          mask;
  logic [CAP_W-1:0]          poly;
  logic [CAP_W-1:0]          rem_m;
  logic                      top;
  logic [CAP_W-1:0]          rem_gen;
  logic [CAP_W-1:0]          rem_chk;
  logic                      accept;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      divisor_r     <= sccg_pkg::DIVISOR_RST;
      check_width_r <= sccg_pkg::WIDTH_RST;
      check_mode_r  <= sccg_pkg::MODE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sccg_pkg::CFG_DIVISOR: divisor_r     <= cfg_data;
        sccg_pkg::CFG_WIDTH:   check_width_r <= cfg_data[sccg_pkg::CW_W-1:0];
        sccg_pkg::CFG_MODE:    check_mode_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Effective CRC length, clamped to 1..CAP_W
  always_comb begin
    if (check_width_r == '0) begin
      eff_w = sccg_pkg::CW_W'(1);
    end else if (check_width_r > CAP_WV) begin
      eff_w = CAP_WV;
    end else begin
      eff_w = check_width_r;
    end
  end

  // Width mask and leading remainder bit
  always_comb begin
    mask = '0;
    top  = 1'b0;
    for (int i = 0; i < CAP_W; i++) begin
      mask[i] = (sccg_pkg::CW_W'(i) < eff_w);
      top     = top | (rem_r[i] & (sccg_pkg::CW_W'(i) == (eff_w - 1'b1)));
    end
  end

  assign poly  = divisor_r[CAP_W-1:0] & mask;
  assign rem_m = rem_r & mask;

  // One division step: augmented for generate, plain for check
  assign rem_gen = ((rem_m << 1) & mask) ^ ((top ^ in_data_bit) ? poly : '0);
  assign rem_chk = (((rem_m << 1) | CAP_W'(in_data_bit)) & mask) ^ (top ? poly : '0);

  assign in_stall = full_i;
  assign accept   = in_valid & ~full_i;

  // Running remainder, cleared after the final bit
  always_comb begin
    rem_nxt = rem_r;
    if (accept) begin
      if (in_final_bit) begin
        rem_nxt = '0;
      end else begin
        rem_nxt = check_mode_r ? rem_chk : rem_gen;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

  // Classify the request; check bits before the last make no job
  assign push_o = accept & (~check_mode_r | in_final_bit);

  always_comb begin
    job_o.data_bit = in_data_bit;
    job_o.error    = |rem_chk;
    job_o.width    = eff_w;
    if (check_mode_r) begin
      job_o.kind = sccg_pkg::JOB_VERDICT;
    end else if (in_final_bit) begin
      job_o.kind = sccg_pkg::JOB_CRC;
    end else begin
      job_o.kind = sccg_pkg::JOB_ECHO;
    end
  end

  assign rem_o = rem_gen;

endmodule

/* design/sccg_queue.sv */
// Short register queue carrying jobs from front to back.
module sccg_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = sccg_pkg::QUEUE_DEPTH,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] din,
  input  logic              pop,
  output logic [DATA_W-1:0] dout,
  output logic              full,
  output logic              empty
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign dout  = mem_r[rd_ptr_r];

  // Pointer and fill-count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue fill count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full && !pop |=> count_r == CNT_W'(DEPTH))
    else $error("queue lost an entry while full");
`endif

endmodule

/* design/sccg_back.sv */
// Back end: turns queued jobs into result items through an output register.
module sccg_back #(
  parameter int MAX_CHECK_WIDTH = sccg_pkg::MAX_CHECK_WIDTH,
  localparam int CAP_W = (MAX_CHECK_WIDTH < 32) ? MAX_CHECK_WIDTH : 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              empty_i,
  input  sccg_pkg::job_t    job_i,
  input  logic [CAP_W-1:0]  rem_i,
  output logic              pop_o,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_code_bit,
  output logic              out_is_check_bit,
  output logic              out_error_found,
  output logic              out_run_end
);

  localparam logic [sccg_pkg::CW_W-1:0] CAP_WV = sccg_pkg::CW_W'(CAP_W);

  logic                      out_valid_r,     out_valid_nxt;
  logic                      code_bit_r,      code_bit_nxt;
  logic                      is_check_bit_r,  is_check_bit_nxt;
  logic                      error_found_r,   error_found_nxt;
  logic                      run_end_r,       run_end_nxt;
  logic [CAP_W-1:0]          shift_r,         shift_nxt;
  logic [sccg_pkg::CW_W-1:0] cnt_r,           cnt_nxt;
  logic                      advance;

  assign advance = ~out_valid_r | ~out_stall;

  // Result selection: CRC tail first, then the next queued job
  always_comb begin
    out_valid_nxt    = out_valid_r;
    code_bit_nxt     = code_bit_r;
    is_check_bit_nxt = is_check_bit_r;
    error_found_nxt  = error_found_r;
    run_end_nxt      = run_end_r;
    shift_nxt        = shift_r;
    cnt_nxt          = cnt_r;
    pop_o            = 1'b0;
    if (advance) begin
      if (cnt_r != '0) begin
        out_valid_nxt    = 1'b1;
        code_bit_nxt     = shift_r[CAP_W-1];
        is_check_bit_nxt = 1'b1;
        error_found_nxt  = 1'b0;
        run_end_nxt      = (cnt_r == sccg_pkg::CW_W'(1));
        shift_nxt        = shift_r << 1;
        cnt_nxt          = cnt_r - 1'b1;
      end else if (!empty_i) begin
        pop_o            = 1'b1;
        out_valid_nxt    = 1'b1;
        is_check_bit_nxt = 1'b0;
        unique case (job_i.kind)
          sccg_pkg::JOB_ECHO: begin
            code_bit_nxt    = job_i.data_bit;
            error_found_nxt = 1'b0;
            run_end_nxt     = 1'b1;
          end
          sccg_pkg::JOB_CRC: begin
            code_bit_nxt    = job_i.data_bit;
            error_found_nxt = 1'b0;
            run_end_nxt     = 1'b0;
            // align the remainder's top bit to the MSB of the shifter
            shift_nxt       = rem_i << (CAP_WV - job_i.width);
            cnt_nxt         = job_i.width;
          end
          sccg_pkg::JOB_VERDICT: begin
            code_bit_nxt    = 1'b0;
            error_found_nxt = job_i.error;
            run_end_nxt     = 1'b1;
          end
          default: begin
            code_bit_nxt    = 1'b0;
            error_found_nxt = 1'b0;
            run_end_nxt     = 1'b1;
          end
        endcase
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    code_bit_r     <= code_bit_nxt;
    is_check_bit_r <= is_check_bit_nxt;
    error_found_r  <= error_found_nxt;
    run_end_r      <= run_end_nxt;
    shift_r        <= shift_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_code_bit     = code_bit_r;
  assign out_is_check_bit = is_check_bit_r;
  assign out_error_found  = error_found_r;
  assign out_run_end      = run_end_r;

`ifndef ASSERT_OFF
  a_tail_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != '0 |-> out_valid_r)
    else $error("CRC tail pending without a valid result");

  a_tail_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && is_check_bit_r && run_end_r |-> cnt_r == '0)
    else $error("last CRC bit shown with tail bits left");
`endif

endmodule

/* design/serial_crc_generate_check_unit.sv */
// Top level of the bit-serial CRC generate/check unit.
//
//  channel  dir  handshake          payload
//  in_      in   in_valid/in_stall  in_data_bit, in_final_bit
//  out_     out  out_valid/out_stall out_code_bit, out_is_check_bit, out_error_found, out_run_end
//  cfg_     in   cfg_valid/cfg_ready cfg_index[1:0], cfg_data[31:0]
//
// One input bit is taken per cycle while in_stall is low; the remainder update is a single XOR step in the front.
// With the back end idle, a request's result is written into the job queue and then into the output register.
// A final bit in generate mode occupies the back end while it emits the code bit and then the CRC bits; the
// four-entry job queue absorbs input meanwhile, and in_stall rises only when it is full.
// Synchronous active-low reset clears the remainder, empties the queue and clears out_valid.
// cfg_ready is always high; writes take effect on the next cycle.
module serial_crc_generate_check_unit #(
  parameter int MAX_CHECK_WIDTH = sccg_pkg::MAX_CHECK_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_data_bit,
  input  logic        in_final_bit,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_code_bit,
  output logic        out_is_check_bit,
  output logic        out_error_found,
  output logic        out_run_end
);

  localparam int CAP_W  = (MAX_CHECK_WIDTH < 32) ? MAX_CHECK_WIDTH : 32;
  localparam int JOB_W  = $bits(sccg_pkg::job_t);
  localparam int DATA_W = JOB_W + CAP_W;

  logic              push;
  logic              pop;
  logic              full;
  logic              empty;
  sccg_pkg::job_t    job_in;
  sccg_pkg::job_t    job_out;
  logic [CAP_W-1:0]  rem_in;
  logic [CAP_W-1:0]  rem_out;
  logic [DATA_W-1:0] q_din;
  logic [DATA_W-1:0] q_dout;

  assign cfg_ready = 1'b1;

  // Front: division and classification
  sccg_front #(
    .MAX_CHECK_WIDTH(MAX_CHECK_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_data_bit  (in_data_bit),
    .in_final_bit (in_final_bit),
    .in_stall     (in_stall),
    .full_i       (full),
    .push_o       (push),
    .job_o        (job_in),
    .rem_o        (rem_in)
  );

  // Job queue
  assign q_din   = {job_in, rem_in};
  assign job_out = sccg_pkg::job_t'(q_dout[DATA_W-1:CAP_W]);
  assign rem_out = q_dout[CAP_W-1:0];

  sccg_queue #(
    .DATA_W (DATA_W),
    .DEPTH  (sccg_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (q_din),
    .pop   (pop),
    .dout  (q_dout),
    .full  (full),
    .empty (empty)
  );

  // Back: result sequencing
  sccg_back #(
    .MAX_CHECK_WIDTH(MAX_CHECK_WIDTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .empty_i          (empty),
    .job_i            (job_out),
    .rem_i            (rem_out),
    .pop_o            (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_code_bit     (out_code_bit),
    .out_is_check_bit (out_is_check_bit),
    .out_error_found  (out_error_found),
    .out_run_end      (out_run_end)
  );

`ifndef ASSERT_OFF
  a_verdict_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_found |-> !out_is_check_bit && !out_code_bit && out_run_end)
    else $error("verdict result carries code bits");
`endif

endmodule
